/* hw/rtl/cossim_pkg.sv */
`default_nettype none

package cossim_pkg;

    // field and accumulator widths
    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int NORM_W  = 24;
    localparam int COS_W   = 16;

    // shared square root unit: wide radicand, one root bit per cycle
    localparam int RAD_W      = 2 * ACC_W;
    localparam int ROOT_W     = ACC_W;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    // sum-of-squares product built from half-width partial products
    localparam int HALF_W    = ACC_W / 2;
    localparam int MUL_STEPS = 4;
    localparam int MUL_CNT_W = 3;

    // quotient needs the cosine bits plus one guard bit for the clamp
    localparam int DIV_STEPS = COS_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // output packing
    localparam int TDATA_OUT_W = COS_W + ACC_W + NORM_W;
    localparam int TUSER_OUT_W = 2;
    localparam int TDATA_IN_W  = 2 * ELEM_W;

    // controller to datapath commands
    typedef struct packed {
        logic take;
        logic sqrt_start;
        logic sqrt_sel_den;
        logic norm_load;
        logic den_load;
        logic mul_start;
        logic div_start;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sqrt_busy;
        logic sqrt_done;
        logic mul_busy;
        logic div_done;
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hw/rtl/cosine_similarity_stream.sv */
// Streaming cosine similarity of two vectors.
// Input channel (i_s_*): one element pair per transfer, elem_a in tdata[15:0],
// elem_b in tdata[31:16], tlast on the final pair of the vectors. Pairs are
// taken one per cycle while a vector pair is being accumulated.
// Output channel (o_m_*): one result per vector pair: cosine (Q1.15),
// dot product and norm of the first vector in tdata, zero-norm and
// overflow flags in tuser.
// The back end runs a shared square root unit that yields one root bit per
// cycle twice, first for the norm and then for the denominator, and then a
// restoring divider that forms the cosine.
// While the back end runs, tready is low. A finished result waits in the
// output register; the next vector is accepted meanwhile, and only its own
// result waits until the receiver takes the previous one.
// Reset (synchronous, active low) clears the accumulators, count and flags
// and drops any result not yet transferred.
`default_nettype none

module cosine_similarity_stream #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_LENGTH   = 65536
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // slave side
    input  wire logic                                   i_s_tvalid,
    output logic                                        o_s_tready,
    // elem_a [15:0], elem_b [31:16]
    input  wire logic [cossim_pkg::TDATA_IN_W-1:0]      i_s_tdata,
    // last_element
    input  wire logic                                   i_s_tlast,
    // master side
    output logic                                        o_m_tvalid,
    input  wire logic                                   i_m_tready,
    // cosine [15:0], dot_product [63:16], norm_a [87:64]
    output logic [cossim_pkg::TDATA_OUT_W-1:0]          o_m_tdata,
    // zero_norm [0], overflow [1]
    output logic [cossim_pkg::TUSER_OUT_W-1:0]          o_m_tuser
);

    cossim_pkg::t_dp_cmd w_cmd;
    cossim_pkg::t_dp_sts w_sts;

    logic [cossim_pkg::COS_W-1:0]  w_cosine;
    logic [cossim_pkg::ACC_W-1:0]  w_dot_product;
    logic [cossim_pkg::NORM_W-1:0] w_norm_a;
    logic                          w_zero_norm;
    logic                          w_overflow;

    // sequencing
    cossim_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // accumulation, root, product, division and output register
    cossim_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_elem_a      (i_s_tdata[cossim_pkg::ELEM_W-1:0]),
        .i_elem_b      (i_s_tdata[2*cossim_pkg::ELEM_W-1:cossim_pkg::ELEM_W]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_cosine      (w_cosine),
        .o_dot_product (w_dot_product),
        .o_norm_a      (w_norm_a),
        .o_zero_norm   (w_zero_norm),
        .o_overflow    (w_overflow)
    );

    // result packing
    assign o_m_tdata = {w_norm_a, w_dot_product, w_cosine};
    assign o_m_tuser = {w_overflow, w_zero_norm};

endmodule

`default_nettype wire

/* hw/rtl/cossim_sqrt.sv */
`default_nettype none

module cossim_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [cossim_pkg::RAD_W-1:0]  i_radicand,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [cossim_pkg::ROOT_W-1:0]      o_root
);

    localparam int REM_W = cossim_pkg::ROOT_W + 2;

    logic                                  r_busy;
    logic                                  r_done;
    logic [cossim_pkg::SQRT_CNT_W-1:0]     r_cnt;
    logic [cossim_pkg::RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]                      r_rem;
    logic [cossim_pkg::ROOT_W-1:0]         r_root;

    logic [REM_W-1:0] w_rem_sh;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    // one restoring step: bring down two radicand bits, try root bit one
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[cossim_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cossim_pkg::SQRT_CNT_W'(cossim_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder, root and radicand shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[cossim_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[cossim_pkg::ROOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* hw/rtl/cossim_dp.sv */
`default_nettype none

module cossim_dp #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int MAX_LENGTH   = 65536
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [cossim_pkg::ELEM_W-1:0]        i_elem_a,
    input  wire logic [cossim_pkg::ELEM_W-1:0]        i_elem_b,
    input  wire cossim_pkg::t_dp_cmd                  i_cmd,
    output cossim_pkg::t_dp_sts                       o_sts,
    input  wire logic                                 i_m_tready,
    output logic                                      o_m_tvalid,
    output logic [cossim_pkg::COS_W-1:0]              o_cosine,
    output logic [cossim_pkg::ACC_W-1:0]              o_dot_product,
    output logic [cossim_pkg::NORM_W-1:0]             o_norm_a,
    output logic                                      o_zero_norm,
    output logic                                      o_overflow
);

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
    localparam int ACC_W  = cossim_pkg::ACC_W;
    localparam int HALF_W = cossim_pkg::HALF_W;
    localparam int DIV_N  = cossim_pkg::DIV_STEPS;
    localparam logic [DIV_N-1:0] Q_NEG_LIM = DIV_N'(2 ** (cossim_pkg::COS_W - 1));
    localparam logic [DIV_N-1:0] Q_POS_LIM = DIV_N'(2 ** (cossim_pkg::COS_W - 1) - 1);
    localparam logic [cossim_pkg::COS_W-1:0] COS_NEG_MAX = {1'b1, {(cossim_pkg::COS_W-1){1'b0}}};
    localparam logic [cossim_pkg::COS_W-1:0] COS_POS_MAX = {1'b0, {(cossim_pkg::COS_W-1){1'b1}}};

    // saturating add at the signed accumulator limits
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [ACC_W:0]   add);
        logic [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + add;
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    // sample extraction from the element fields
    logic [SAMPLE_WIDTH-1:0] w_a_raw;
    logic [SAMPLE_WIDTH-1:0] w_b_raw;

    generate
        if (SAMPLE_WIDTH <= cossim_pkg::ELEM_W) begin : g_narrow
            assign w_a_raw = i_elem_a[SAMPLE_WIDTH-1:0];
            assign w_b_raw = i_elem_b[SAMPLE_WIDTH-1:0];
        end else begin : g_wide
            assign w_a_raw = {{(SAMPLE_WIDTH-cossim_pkg::ELEM_W){1'b0}}, i_elem_a};
            assign w_b_raw = {{(SAMPLE_WIDTH-cossim_pkg::ELEM_W){1'b0}}, i_elem_b};
        end
    endgenerate

    logic signed [SAMPLE_WIDTH-1:0] w_a;
    logic signed [SAMPLE_WIDTH-1:0] w_b;
    assign w_a = $signed(w_a_raw);
    assign w_b = $signed(w_b_raw);

    // product stage
    logic signed [PROD_W-1:0] r_p_ab;
    logic signed [PROD_W-1:0] r_p_aa;
    logic signed [PROD_W-1:0] r_p_bb;
    logic                     r_p_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_p_ab <= w_a * w_b;
            r_p_aa <= w_a * w_a;
            r_p_bb <= w_b * w_b;
        end
    end

    logic [ACC_W:0] w_ext_ab;
    logic [ACC_W:0] w_ext_aa;
    logic [ACC_W:0] w_ext_bb;
    assign w_ext_ab = {{(ACC_W+1-PROD_W){r_p_ab[PROD_W-1]}}, r_p_ab};
    assign w_ext_aa = {{(ACC_W+1-PROD_W){r_p_aa[PROD_W-1]}}, r_p_aa};
    assign w_ext_bb = {{(ACC_W+1-PROD_W){r_p_bb[PROD_W-1]}}, r_p_bb};

    // accumulators, element count and overflow flag
    logic [ACC_W-1:0] r_dot;
    logic [ACC_W-1:0] r_sq_a;
    logic [ACC_W-1:0] r_sq_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_dot  <= '0;
            r_sq_a <= '0;
            r_sq_b <= '0;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (r_p_vld) begin
                r_dot  <= sat_add(r_dot, w_ext_ab);
                r_sq_a <= sat_add(r_sq_a, w_ext_aa);
                r_sq_b <= sat_add(r_sq_b, w_ext_bb);
            end
            if (i_cmd.take) begin
                if (r_cnt >= CNT_W'(MAX_LENGTH)) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // product of both sums of squares, one partial product per cycle
    logic                                r_mul_busy;
    logic [cossim_pkg::MUL_CNT_W-1:0]    r_mul_cnt;
    logic [2*HALF_W-1:0]                 r_pp;
    logic [1:0]                          r_pp_sh;
    logic                                r_pp_vld;
    logic [cossim_pkg::RAD_W-1:0]        r_mprod;

    logic [1:0]                          w_pp_idx;
    logic [HALF_W-1:0]                   w_half_a;
    logic [HALF_W-1:0]                   w_half_b;
    logic [cossim_pkg::RAD_W-1:0]        w_pp_shifted;

    assign w_pp_idx = r_mul_cnt[1:0];
    assign w_half_a = w_pp_idx[1] ? r_sq_a[ACC_W-1:HALF_W] : r_sq_a[HALF_W-1:0];
    assign w_half_b = w_pp_idx[0] ? r_sq_b[ACC_W-1:HALF_W] : r_sq_b[HALF_W-1:0];

    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_shifted = {{(2*HALF_W){1'b0}}, r_pp};
            2'd1:    w_pp_shifted = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
            2'd2:    w_pp_shifted = {r_pp, {(2*HALF_W){1'b0}}};
            default: w_pp_shifted = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_cnt  <= '0;
            r_pp_vld   <= 1'b0;
        end else begin
            if (i_cmd.mul_start) begin
                r_mul_busy <= 1'b1;
                r_mul_cnt  <= '0;
                r_pp_vld   <= 1'b0;
            end else if (r_mul_busy) begin
                r_mul_cnt <= r_mul_cnt + 1'b1;
                if (r_mul_cnt < cossim_pkg::MUL_CNT_W'(cossim_pkg::MUL_STEPS)) begin
                    r_pp_vld <= 1'b1;
                end else begin
                    r_pp_vld   <= 1'b0;
                    r_mul_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mul_busy) begin
            r_pp    <= w_half_a * w_half_b;
            r_pp_sh <= {1'b0, w_pp_idx[1]} + {1'b0, w_pp_idx[0]};
        end
        if (i_cmd.mul_start) begin
            r_mprod <= '0;
        end else if (r_pp_vld) begin
            r_mprod <= r_mprod + w_pp_shifted;
        end
    end

    // shared square root: first the norm, then the denominator
    logic                                w_sqrt_busy;
    logic                                w_sqrt_done;
    logic [cossim_pkg::ROOT_W-1:0]       w_root;
    logic [cossim_pkg::RAD_W-1:0]        w_rad;

    assign w_rad = i_cmd.sqrt_sel_den ? r_mprod
                                      : {{(cossim_pkg::RAD_W-ACC_W){1'b0}}, r_sq_a};

    cossim_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (w_rad),
        .o_busy     (w_sqrt_busy),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    logic [cossim_pkg::NORM_W-1:0] r_norm;
    logic [cossim_pkg::ROOT_W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_load) begin
            r_norm <= w_root[cossim_pkg::NORM_W-1:0];
        end
        if (i_cmd.den_load) begin
            r_den <= w_root;
        end
    end

    // restoring division of |dot| * 2^15 by the denominator
    logic                                r_div_busy;
    logic                                r_div_done;
    logic [cossim_pkg::DIV_CNT_W-1:0]    r_div_cnt;
    logic [ACC_W-1:0]                    r_div_rem;
    logic [DIV_N-1:0]                    r_div_bits;
    logic [DIV_N-1:0]                    r_div_q;
    logic                                r_div_sat;

    logic [ACC_W-1:0]                    w_mag;
    logic [ACC_W:0]                      w_dsh;
    logic [ACC_W:0]                      w_dsub;
    logic                                w_dge;

    assign w_mag  = r_dot[ACC_W-1] ? (~r_dot + 1'b1) : r_dot;
    assign w_dsh  = {r_div_rem, r_div_bits[DIV_N-1]};
    assign w_dge  = (w_dsh >= {1'b0, r_den});
    assign w_dsub = w_dsh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_done <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= '0;
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                if (r_div_cnt == cossim_pkg::DIV_CNT_W'(DIV_N - 1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            // quotient of 2^17 or more clamps anyway
            r_div_sat  <= ({2'b00, w_mag} >= {r_den, 2'b00});
            r_div_rem  <= {2'b00, w_mag[ACC_W-1:2]};
            r_div_bits <= {w_mag[1:0], {(DIV_N-2){1'b0}}};
            r_div_q    <= '0;
        end else if (r_div_busy) begin
            r_div_rem  <= w_dge ? w_dsub[ACC_W-1:0] : w_dsh[ACC_W-1:0];
            r_div_bits <= {r_div_bits[DIV_N-2:0], 1'b0};
            r_div_q    <= {r_div_q[DIV_N-2:0], w_dge};
        end
    end

    // cosine sign, clamp and zero norm
    logic                          w_zero;
    logic [DIV_N-1:0]              w_q_neg;
    logic [cossim_pkg::COS_W-1:0]  w_cos;

    assign w_zero  = (r_den == '0);
    assign w_q_neg = ~r_div_q + 1'b1;

    always_comb begin
        if (w_zero) begin
            w_cos = '0;
        end else if (r_dot[ACC_W-1]) begin
            w_cos = (r_div_sat || r_div_q > Q_NEG_LIM) ? COS_NEG_MAX
                                                       : w_q_neg[cossim_pkg::COS_W-1:0];
        end else begin
            w_cos = (r_div_sat || r_div_q > Q_POS_LIM) ? COS_POS_MAX
                                                       : r_div_q[cossim_pkg::COS_W-1:0];
        end
    end

    // output register
    logic                          r_out_vld;
    logic [cossim_pkg::COS_W-1:0]  r_out_cos;
    logic [ACC_W-1:0]              r_out_dot;
    logic [cossim_pkg::NORM_W-1:0] r_out_norm;
    logic                          r_out_zero;
    logic                          r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cos  <= w_cos;
            r_out_dot  <= r_dot;
            r_out_norm <= r_norm;
            r_out_zero <= w_zero;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_m_tvalid    = r_out_vld;
    assign o_cosine      = r_out_cos;
    assign o_dot_product = r_out_dot;
    assign o_norm_a      = r_out_norm;
    assign o_zero_norm   = r_out_zero;
    assign o_overflow    = r_out_ovf;

    // status back to the controller
    assign o_sts.sqrt_busy = w_sqrt_busy;
    assign o_sts.sqrt_done = w_sqrt_done;
    assign o_sts.mul_busy  = r_mul_busy;
    assign o_sts.div_done  = r_div_done;
    assign o_sts.out_full  = r_out_vld && !i_m_tready;

endmodule

`default_nettype wire

/* hw/rtl/cossim_ctrl.sv */
`default_nettype none

module cossim_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tlast,
    output logic                        o_s_tready,
    output cossim_pkg::t_dp_cmd         o_cmd,
    input  wire cossim_pkg::t_dp_sts    i_sts
);

    typedef enum logic [8:0] {
        S_ACC       = 9'b000000001,
        S_DRAIN     = 9'b000000010,
        S_NORM      = 9'b000000100,
        S_NORM_WAIT = 9'b000001000,
        S_DEN       = 9'b000010000,
        S_DEN_WAIT  = 9'b000100000,
        S_DIV       = 9'b001000000,
        S_DIV_WAIT  = 9'b010000000,
        S_OUT       = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_ACC: begin
                o_s_tready = 1'b1;
                o_cmd.take = i_s_tvalid;
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last products land in the accumulators
                n_state = S_NORM;
            end
            S_NORM: begin
                o_cmd.sqrt_start = 1'b1;
                o_cmd.mul_start  = 1'b1;
                n_state          = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.norm_load = 1'b1;
                    n_state         = S_DEN;
                end
            end
            S_DEN: begin
                o_cmd.sqrt_sel_den = 1'b1;
                if (!i_sts.mul_busy) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = S_DEN_WAIT;
                end
            end
            S_DEN_WAIT: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.den_load = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // checks
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_full)
        else $error("result loaded over a waiting result");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sqrt_start |-> !i_sts.sqrt_busy)
        else $error("square root started while busy");

    a_den_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.sqrt_start && o_cmd.sqrt_sel_den) |-> !i_sts.mul_busy)
        else $error("denominator root started before product done");

    a_last_stops_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_s_tlast) |=> !o_s_tready)
        else $error("input still open after last transfer");

endmodule

`default_nettype wire
